// ----- design/dqp_pkg.sv -----
// Shared constants and codes for the DNS query question parser.
package dqp_pkg;

    localparam logic [7:0] MAX_NAME_LEN  = 8'd255;
    localparam logic [7:0] MAX_LABEL_LEN = 8'd63;
    localparam logic [3:0] HEADER_BYTES  = 4'd12;
    localparam logic [7:0] DOT_CHAR      = 8'd46;
    localparam int         HEADER_WORDS  = 6;

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_DONE      = 2'd1,
        KIND_LABEL_ERR = 2'd2,
        KIND_NAME_ERR  = 2'd3
    } kind_t;

endpackage

// ----- design/dqp_if.sv -----
// Valid/ready channel interfaces for message bytes and parse results.
interface dqp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       start_of_message;

    modport source (output valid, output byte_value, output start_of_message, input ready);
    modport sink   (input valid, input byte_value, input start_of_message, output ready);
endinterface

interface dqp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [7:0]  name_index;
    logic [15:0] message_id;
    logic [15:0] flags_word;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic [15:0] query_type;
    logic [15:0] query_class;

    modport source (
        output valid, input ready,
        output kind, output name_char, output name_index,
        output message_id, output flags_word, output question_count,
        output answer_count, output authority_count, output additional_count,
        output query_type, output query_class
    );
    modport sink (
        input valid, output ready,
        input kind, input name_char, input name_index,
        input message_id, input flags_word, input question_count,
        input answer_count, input authority_count, input additional_count,
        input query_type, input query_class
    );
endinterface

// ----- design/dns_query_question_parser_unit.sv -----
// DNS query header and question parser: one message byte in, at most one result out.
//
// The parser takes one message byte per clock cycle. A byte with start_of_message
// set restarts parsing in any phase and counts as header byte 0. The first twelve
// bytes fill six big-endian header words, then the length-prefixed QNAME is
// decoded: every label byte comes out as a name character (kind 0) and every
// length byte after the first comes out as a dot, each with its position in the
// dotted name. A zero byte ends the name; QTYPE and QCLASS follow, and the last
// QCLASS byte produces one "done" transaction (kind 1) carrying all header words,
// QTYPE, QCLASS and the name length. A label longer than MAX_LABEL_LEN gives
// kind 2, a name reaching MAX_NAME_LEN bytes gives kind 3; after done or an error
// bytes are dropped until the next start. Each byte is handled by the phase/counter
// update feeding one result register, so a byte can be accepted every cycle; the
// result is registered and appears in the cycle after its byte. Input ready
// drops only while the result register holds a transaction the sink has not taken.
module dns_query_question_parser_unit (
    input  logic         clk,
    input  logic         rst_n,
    dqp_byte_if.sink     query,
    dqp_result_if.source result
);
    import dqp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_FIRSTLEN,
        PH_NAME,
        PH_TYPE_HI,
        PH_TYPE_LO,
        PH_CLASS_HI,
        PH_CLASS_LO
    } phase_t;

    // Parser control state
    phase_t      phase_reg, phase_next;
    logic [3:0]  byte_cnt_reg, byte_cnt_next;
    logic [7:0]  label_rem_reg, label_rem_next;
    logic [7:0]  name_pos_reg, name_pos_next;

    // Message payload stores; each is written before the done result reads it
    logic [15:0] header_reg [HEADER_WORDS];
    logic [15:0] type_reg;
    logic [7:0]  class_hi_reg;

    // Result register
    logic        out_valid_reg;
    kind_t       kind_reg;
    logic [7:0]  char_reg;
    logic [7:0]  index_reg;
    logic [15:0] words_reg [HEADER_WORDS];
    logic [15:0] qtype_out_reg;
    logic [15:0] qclass_out_reg;

    // Per-byte decode
    logic        accept;
    phase_t      cur_phase;
    logic [3:0]  cur_cnt;
    logic [7:0]  cur_label;
    logic [7:0]  cur_pos;
    logic        hdr_we;
    logic        type_hi_we;
    logic        type_lo_we;
    logic        class_hi_we;
    logic        emit;
    kind_t       kind_next;
    logic [7:0]  char_next;
    logic [7:0]  index_next;
    logic        done_next;

    // Take a new byte whenever the result register is empty or being drained
    assign query.ready = !out_valid_reg || result.ready;
    assign accept      = query.valid && query.ready;

    always_comb
    begin
        // A start byte restarts the parser before the byte is decoded
        cur_phase = query.start_of_message ? PH_HEADER : phase_reg;
        cur_cnt   = query.start_of_message ? 4'd0 : byte_cnt_reg;
        cur_label = query.start_of_message ? 8'd0 : label_rem_reg;
        cur_pos   = query.start_of_message ? 8'd0 : name_pos_reg;

        phase_next     = cur_phase;
        byte_cnt_next  = cur_cnt;
        label_rem_next = cur_label;
        name_pos_next  = cur_pos;
        hdr_we         = 1'b0;
        type_hi_we     = 1'b0;
        type_lo_we     = 1'b0;
        class_hi_we    = 1'b0;
        emit           = 1'b0;
        done_next      = 1'b0;
        kind_next      = KIND_CHAR;
        char_next      = 8'd0;
        index_next     = 8'd0;

        case (cur_phase)
            PH_IDLE:
            begin
                // drop the byte
            end
            PH_HEADER:
            begin
                hdr_we = 1'b1;
                if (cur_cnt == HEADER_BYTES - 4'd1)
                begin
                    byte_cnt_next = 4'd0;
                    phase_next    = PH_FIRSTLEN;
                end
                else
                begin
                    byte_cnt_next = cur_cnt + 4'd1;
                end
            end
            PH_FIRSTLEN:
            begin
                if (query.byte_value == 8'd0)
                begin
                    phase_next = PH_TYPE_HI;
                end
                else if (query.byte_value > MAX_LABEL_LEN)
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    kind_next  = KIND_LABEL_ERR;
                    char_next  = query.byte_value;
                end
                else
                begin
                    label_rem_next = query.byte_value;
                    name_pos_next  = 8'd0;
                    phase_next     = PH_NAME;
                end
            end
            PH_NAME:
            begin
                if (cur_pos >= MAX_NAME_LEN)
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    kind_next  = KIND_NAME_ERR;
                    char_next  = query.byte_value;
                    index_next = cur_pos;
                end
                else if (query.byte_value == 8'd0)
                begin
                    phase_next = PH_TYPE_HI;
                end
                else if (cur_label == 8'd0)
                begin
                    // length byte: a dot, unless the label is too long
                    emit       = 1'b1;
                    index_next = cur_pos;
                    if (query.byte_value > MAX_LABEL_LEN)
                    begin
                        phase_next = PH_IDLE;
                        kind_next  = KIND_LABEL_ERR;
                        char_next  = query.byte_value;
                    end
                    else
                    begin
                        label_rem_next = query.byte_value;
                        kind_next      = KIND_CHAR;
                        char_next      = DOT_CHAR;
                        name_pos_next  = cur_pos + 8'd1;
                    end
                end
                else
                begin
                    label_rem_next = cur_label - 8'd1;
                    emit           = 1'b1;
                    kind_next      = KIND_CHAR;
                    char_next      = query.byte_value;
                    index_next     = cur_pos;
                    name_pos_next  = cur_pos + 8'd1;
                end
            end
            PH_TYPE_HI:
            begin
                type_hi_we = 1'b1;
                phase_next = PH_TYPE_LO;
            end
            PH_TYPE_LO:
            begin
                type_lo_we = 1'b1;
                phase_next = PH_CLASS_HI;
            end
            PH_CLASS_HI:
            begin
                class_hi_we = 1'b1;
                phase_next  = PH_CLASS_LO;
            end
            PH_CLASS_LO:
            begin
                emit       = 1'b1;
                done_next  = 1'b1;
                kind_next  = KIND_DONE;
                index_next = cur_pos;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Payload stores: header words, QTYPE and the QCLASS high byte
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (hdr_we)
            begin
                if (cur_cnt[0] == 1'b0)
                begin
                    header_reg[cur_cnt[3:1]] <= {query.byte_value, 8'd0};
                end
                else
                begin
                    header_reg[cur_cnt[3:1]] <= {header_reg[cur_cnt[3:1]][15:8],
                                                 query.byte_value};
                end
            end
            if (type_hi_we)
            begin
                type_reg <= {query.byte_value, 8'd0};
            end
            if (type_lo_we)
            begin
                type_reg <= {type_reg[15:8], query.byte_value};
            end
            if (class_hi_we)
            begin
                class_hi_reg <= query.byte_value;
            end
        end
    end

    // Parser state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_cnt_reg   <= 4'd0;
            label_rem_reg  <= 8'd0;
            name_pos_reg   <= 8'd0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= KIND_CHAR;
            char_reg       <= 8'd0;
            index_reg      <= 8'd0;
            qtype_out_reg  <= 16'd0;
            qclass_out_reg <= 16'd0;
            for (int i = 0; i < HEADER_WORDS; i++)
            begin
                words_reg[i] <= 16'd0;
            end
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                byte_cnt_reg  <= byte_cnt_next;
                label_rem_reg <= label_rem_next;
                name_pos_reg  <= name_pos_next;
                out_valid_reg <= emit;
                if (emit)
                begin
                    kind_reg       <= kind_next;
                    char_reg       <= char_next;
                    index_reg      <= index_next;
                    // header fields are zero except on the done transaction
                    qtype_out_reg  <= done_next ? type_reg : 16'd0;
                    qclass_out_reg <= done_next ? {class_hi_reg, query.byte_value} : 16'd0;
                    for (int i = 0; i < HEADER_WORDS; i++)
                    begin
                        words_reg[i] <= done_next ? header_reg[i] : 16'd0;
                    end
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.kind             = kind_reg;
    assign result.name_char        = char_reg;
    assign result.name_index       = index_reg;
    assign result.message_id       = words_reg[0];
    assign result.flags_word       = words_reg[1];
    assign result.question_count   = words_reg[2];
    assign result.answer_count     = words_reg[3];
    assign result.authority_count  = words_reg[4];
    assign result.additional_count = words_reg[5];
    assign result.query_type       = qtype_out_reg;
    assign result.query_class      = qclass_out_reg;

`ifndef SYNTHESIS
    // The last QCLASS byte always yields a done transaction
    a_done_after_class: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !query.start_of_message && phase_reg == PH_CLASS_LO
        |=> out_valid_reg && kind_reg == KIND_DONE)
        else $error("missing done result after QCLASS");

    // Header byte counter never leaves the header range
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_cnt_reg < HEADER_BYTES)
        else $error("header byte counter out of range");

    // Name characters stay inside the name length limit
    a_char_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_CHAR |-> index_reg < MAX_NAME_LEN)
        else $error("name character index past limit");

    // An empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> query.ready)
        else $error("input stalled with empty result register");
`endif

endmodule
